/* rtl/rgb_led_spi_bit_encoder_defines.svh */
// Assertion macros for the encoder RTL, used by rlse_back.
// Each macro expects clk and rst_n in scope.
`ifndef RGB_LED_SPI_BIT_ENCODER_DEFINES_SVH
`define RGB_LED_SPI_BIT_ENCODER_DEFINES_SVH

// Same-cycle implication.
`define RLSE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RLSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rlse_pkg.sv */
`timescale 1ns / 1ps

package rlse_pkg;

    // Command handed from the front queue to the back sequencer.
    typedef struct packed {
        logic       pixel;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
        logic       frame_end;
    } cmd_t;

    // Configuration register indexes (paddr[3:2]).
    typedef enum logic [1:0] {
        REG_ONE_PATTERN  = 2'd0,
        REG_ZERO_PATTERN = 2'd1,
        REG_RESET_WORDS  = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    localparam logic       REQ_FRAME_RESET = 1'b0;

    localparam logic [7:0] ONE_PATTERN_RST  = 8'd248;
    localparam logic [7:0] ZERO_PATTERN_RST = 8'd192;
    localparam logic [7:0] RESET_WORDS_RST  = 8'd75;

    // Word slot within one colour: four pattern words, then the zero word.
    localparam logic [2:0] POS_ZERO_WORD = 3'd4;
    // Colour slot: green, red, blue.
    localparam logic [1:0] COLOUR_GREEN  = 2'd0;
    localparam logic [1:0] COLOUR_RED    = 2'd1;
    localparam logic [1:0] COLOUR_BLUE   = 2'd2;

    localparam logic [15:0] ZERO_WORD = 16'h0000;
    localparam logic [7:0]  REPEAT_ONE = 8'd1;

endpackage

/* rtl/rlse_front.sv */
`timescale 1ns / 1ps

module rlse_front #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               req_type,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic               frame_end,
    output logic               head_valid,
    output rlse_pkg::cmd_t     head_cmd,
    input  logic               head_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rlse_pkg::cmd_t             queue_reg [DEPTH];
    rlse_pkg::cmd_t             cmd_in;
    logic [PTR_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       wr_en;
    logic                       rd_en;

    // Classify: a frame reset is not a pixel and never carries frame_end.
    always_comb
    begin
        cmd_in.pixel     = (req_type != rlse_pkg::REQ_FRAME_RESET);
        cmd_in.green     = green;
        cmd_in.red       = red;
        cmd_in.blue      = blue;
        cmd_in.frame_end = frame_end & cmd_in.pixel;
    end

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = queue_reg[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = head_pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* rtl/rlse_back.sv */
`timescale 1ns / 1ps

`include "rgb_led_spi_bit_encoder_defines.svh"

module rlse_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  rlse_pkg::cmd_t     head_cmd,
    output logic               head_pop,
    input  logic [7:0]         one_pattern,
    input  logic [7:0]         zero_pattern,
    input  logic [7:0]         reset_words,
    output logic               empty,
    input  logic               pop,
    output logic [15:0]        spi_word,
    output logic [7:0]         repeat_count,
    output logic               last,
    output logic               chain_done
);

    logic [2:0]   pos_reg;
    logic [1:0]   colour_reg;
    logic         out_valid_reg;
    logic [15:0]  word_reg;
    logic [7:0]   rep_reg;
    logic         last_reg;
    logic         done_reg;

    logic [7:0]   colour_byte;
    logic [1:0]   bit_pair;
    logic [15:0]  word_next;
    logic [7:0]   rep_next;
    logic         last_next;
    logic         done_next;
    logic         advance;

    always_comb
    begin
        case (colour_reg)
            rlse_pkg::COLOUR_GREEN: colour_byte = head_cmd.green;
            rlse_pkg::COLOUR_RED:   colour_byte = head_cmd.red;
            default:                colour_byte = head_cmd.blue;
        endcase

        // Two colour bits per word, MSB pair first.
        case (pos_reg)
            3'd0:    bit_pair = colour_byte[7:6];
            3'd1:    bit_pair = colour_byte[5:4];
            3'd2:    bit_pair = colour_byte[3:2];
            default: bit_pair = colour_byte[1:0];
        endcase

        if (head_cmd.pixel && (pos_reg != rlse_pkg::POS_ZERO_WORD))
        begin
            word_next = {bit_pair[1] ? one_pattern : zero_pattern,
                         bit_pair[0] ? one_pattern : zero_pattern};
        end
        else
        begin
            word_next = rlse_pkg::ZERO_WORD;
        end

        if (head_cmd.pixel)
        begin
            rep_next = rlse_pkg::REPEAT_ONE;
        end
        else
        begin
            // A reset count of zero still sends one word.
            rep_next = (reset_words == '0) ? rlse_pkg::REPEAT_ONE : reset_words;
        end

        last_next = !head_cmd.pixel
                    || ((colour_reg == rlse_pkg::COLOUR_BLUE)
                        && (pos_reg == rlse_pkg::POS_ZERO_WORD));
        done_next = head_cmd.pixel && last_next && head_cmd.frame_end;
    end

    // Load the output register when it is free or being drained.
    assign advance  = head_valid && (!out_valid_reg || pop);
    assign head_pop = advance && last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            colour_reg    <= rlse_pkg::COLOUR_GREEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                if (last_next)
                begin
                    pos_reg    <= '0;
                    colour_reg <= rlse_pkg::COLOUR_GREEN;
                end
                else if (pos_reg == rlse_pkg::POS_ZERO_WORD)
                begin
                    pos_reg    <= '0;
                    colour_reg <= colour_reg + 1'b1;
                end
                else
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_reg <= word_next;
            rep_reg  <= rep_next;
            last_reg <= last_next;
            done_reg <= done_next;
        end
    end

    assign empty        = !out_valid_reg;
    assign spi_word     = word_reg;
    assign repeat_count = rep_reg;
    assign last         = last_reg;
    assign chain_done   = done_reg;

    `RLSE_ASSERT_SAME(a_done_on_last, out_valid_reg && done_reg, last_reg, "chain_done without last")
    `RLSE_ASSERT_SAME(a_slot_range, 1'b1, (pos_reg <= rlse_pkg::POS_ZERO_WORD) && (colour_reg <= rlse_pkg::COLOUR_BLUE), "word slot out of range")
    `RLSE_ASSERT_NEXT(a_restart_after_last, head_pop, (pos_reg == '0) && (colour_reg == rlse_pkg::COLOUR_GREEN), "sequencer did not restart")
    `RLSE_ASSERT_SAME(a_mid_pixel_no_pop, advance && head_cmd.pixel && (pos_reg != rlse_pkg::POS_ZERO_WORD), !head_pop, "command dropped mid pixel")

endmodule

/* rtl/rgb_led_spi_bit_encoder.sv */
`timescale 1ns / 1ps

// Bit encoder for a one-wire RGB LED chain fed through a 16-bit SPI shifter.
// Input channel: push/full queue. A frame-reset item (req_type 0) gives one
// zero word with repeat_count = reset_words (0 counts as 1); a pixel item
// gives fifteen words: green, red, blue, each as four pattern words MSB first
// and one zero word. last marks an item's final word, chain_done the final
// word of a pixel flagged frame_end.
// Result channel: empty/pop queue; the oldest word sits on the ports while
// empty is low and a transfer completes when pop is high.
// The first word of an item passes through the command queue and then the
// output register. Throughput: one word per cycle while the receiver pops;
// a pixel takes fifteen words of the sequencer, a frame reset one. The command
// queue (QUEUE_DEPTH entries) keeps taking items while the sequencer works.
// A stalled receiver holds the output register; the sequencer stops and the
// command queue fills, then full rises.
// Reset clears both queues; the registers return to 248, 192 and 75.
// APB registers at 0x0 one_pattern, 0x4 zero_pattern, 0x8 reset_words;
// write them only while the block is idle.

module rgb_led_spi_bit_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic         req_type,
    input  logic [7:0]   red,
    input  logic [7:0]   green,
    input  logic [7:0]   blue,
    input  logic         frame_end,
    output logic         empty,
    input  logic         pop,
    output logic [15:0]  spi_word,
    output logic [7:0]   repeat_count,
    output logic         last,
    output logic         chain_done,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [7:0]           one_pattern_reg;
    logic [7:0]           zero_pattern_reg;
    logic [7:0]           reset_words_reg;
    logic                 cfg_wr;
    rlse_pkg::reg_idx_t   reg_idx;
    logic                 head_valid;
    logic                 head_pop;
    rlse_pkg::cmd_t       head_cmd;

    assign pready  = 1'b1;
    assign reg_idx = rlse_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_pattern_reg  <= rlse_pkg::ONE_PATTERN_RST;
            zero_pattern_reg <= rlse_pkg::ZERO_PATTERN_RST;
            reset_words_reg  <= rlse_pkg::RESET_WORDS_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                rlse_pkg::REG_ONE_PATTERN:  one_pattern_reg  <= pwdata[7:0];
                rlse_pkg::REG_ZERO_PATTERN: zero_pattern_reg <= pwdata[7:0];
                rlse_pkg::REG_RESET_WORDS:  reset_words_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            rlse_pkg::REG_ONE_PATTERN:  prdata = {24'd0, one_pattern_reg};
            rlse_pkg::REG_ZERO_PATTERN: prdata = {24'd0, zero_pattern_reg};
            rlse_pkg::REG_RESET_WORDS:  prdata = {24'd0, reset_words_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    rlse_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .frame_end  (frame_end),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_pop   (head_pop)
    );

    rlse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .head_pop     (head_pop),
        .one_pattern  (one_pattern_reg),
        .zero_pattern (zero_pattern_reg),
        .reset_words  (reset_words_reg),
        .empty        (empty),
        .pop          (pop),
        .spi_word     (spi_word),
        .repeat_count (repeat_count),
        .last         (last),
        .chain_done   (chain_done)
    );

endmodule
